@@ hdl/go_back_n_window_sender_defines.svh @@
// Assertion macros shared by the go-back-n sender RTL.
`ifndef GO_BACK_N_WINDOW_SENDER_DEFINES_SVH
`define GO_BACK_N_WINDOW_SENDER_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define GBN_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define GBN_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/gbn_pkg.sv @@
// Shared types and constants of the go-back-n sender.
package gbn_pkg;

  // Sizing defaults and protocol limits.
  localparam int WINDOW_MAX_DEF = 64;
  localparam int MAX_PAYLOAD    = 1456;
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = 16;

  // Input item opcodes.
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_ACK   = 2'd1;
  localparam logic [1:0] OP_CHUNK = 2'd2;
  localparam logic [1:0] OP_BEGIN = 2'd3;

  // Packet type that marks a received ACK.
  localparam logic [1:0] ACK_TYPE_ACK = 2'd3;

  // Outgoing packet types.
  localparam logic [1:0] PKT_START = 2'd0;
  localparam logic [1:0] PKT_END   = 2'd1;
  localparam logic [1:0] PKT_DATA  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT     = 1'd1;

  // Operations of the shared sequence-number unit.
  typedef enum logic {
    ALU_SUB,
    ALU_INC
  } alu_op_t;

  // Result of the shared unit: difference or increment, borrow and zero flags.
  typedef struct packed {
    logic [31:0] sum;
    logic        borrow;
    logic        zero;
  } alu_res_t;

  // One outgoing result item.
  typedef struct packed {
    logic [1:0]  pkt_type;
    logic [31:0] seq_number;
    logic [10:0] payload_length;
    logic [5:0]  slot_index;
    logic        is_resend;
    logic        status;
    logic        last;
  } result_t;

endpackage

@@ hdl/gbn_alu.sv @@
// Shared 32-bit subtract and increment unit used by the sender sequencer.
module gbn_alu (
  input  gbn_pkg::alu_op_t  op,
  input  logic [31:0]       a,
  input  logic [31:0]       b,
  output gbn_pkg::alu_res_t res
);
  import gbn_pkg::*;

  logic [32:0] wide;

  // One 33-bit adder serves both the compare and the increment.
  always_comb begin
    unique case (op)
      ALU_SUB: wide = {1'b0, a} - {1'b0, b};
      ALU_INC: wide = {1'b0, a} + 33'd1;
      default: wide = '0;
    endcase
    res.sum    = wide[31:0];
    res.borrow = (op == ALU_SUB) ? wide[32] : 1'b0;
    res.zero   = (wide[31:0] == 32'd0);
  end

endmodule

@@ hdl/gbn_slot_mem.sv @@
// Payload length store, one entry per window slot, with a registered read.
module gbn_slot_mem #(
  parameter int DEPTH = gbn_pkg::WINDOW_MAX_DEF,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [10:0]   wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [10:0]   rd_data
);
  import gbn_pkg::*;

  logic [10:0] mem_r [DEPTH];
  logic [10:0] rd_data_r;

  // One write port and one read port, read data registered.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ hdl/go_back_n_window_sender.sv @@
// Top level of the go-back-n window sender: sequencer, window state and output register.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid / in_stall   | opcode, ack_type, ack_seq, chunk_length
//   out_    | output    | out_valid / out_stall | pkt_type, seq_number, payload_length,
//           |           |                       | slot_index, is_resend, status, last
//   cfg_    | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// An item keeps in_stall high from its transfer until the block is back in idle.
// A data-phase timeout resends each outstanding packet in read, compare and emit steps.
// The steps come from the single shared 32-bit subtract unit, used once a cycle,
// and the one read port of the slot length store.
// Reset is synchronous; the slot store needs no clearing pass.
// A stalled result holds in the output register while the next item is taken.
module go_back_n_window_sender #(
  parameter int WINDOW_MAX = gbn_pkg::WINDOW_MAX_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     in_opcode,
  input  logic [1:0]                     in_ack_type,
  input  logic [31:0]                    in_ack_seq,
  input  logic [10:0]                    in_chunk_length,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     out_pkt_type,
  output logic [31:0]                    out_seq_number,
  output logic [10:0]                    out_payload_length,
  output logic [5:0]                     out_slot_index,
  output logic                           out_is_resend,
  output logic                           out_status,
  output logic                           out_last,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [gbn_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gbn_pkg::CFG_DATA_W-1:0] cfg_data
);
  import gbn_pkg::*;

  `include "go_back_n_window_sender_defines.svh"

  localparam int SLOT_W  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int EFF_CAP = (WINDOW_MAX < 64) ? WINDOW_MAX : 64;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DEC,
    S_ACK2,
    S_TICK,
    S_CHUNK2,
    S_CHUNK3,
    S_RS_RD,
    S_RS_CMP,
    S_EMIT
  } state_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_START,
    PH_DATA,
    PH_DONE
  } phase_t;

  // Registers and their next values.
  state_t            state_r, state_nxt;
  phase_t            phase_r, phase_nxt;
  logic [31:0]       base_r, base_nxt;
  logic [31:0]       next_seq_r, next_seq_nxt;
  logic              done_r, done_nxt;
  logic [15:0]       tick_r, tick_nxt;
  logic [SLOT_W-1:0] base_slot_r, base_slot_nxt;
  logic [SLOT_W-1:0] next_slot_r, next_slot_nxt;
  logic [31:0]       cur_seq_r, cur_seq_nxt;
  logic [SLOT_W-1:0] cur_slot_r, cur_slot_nxt;
  logic [31:0]       seq_inc_r, seq_inc_nxt;
  logic [31:0]       diff_r, diff_nxt;
  logic              eq_r, eq_nxt;
  result_t           pend_r, pend_nxt;
  result_t           out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        op_r, op_nxt;
  logic [1:0]        atype_r, atype_nxt;
  logic [31:0]       aseq_r, aseq_nxt;
  logic [10:0]       clen_r, clen_nxt;
  logic [6:0]        wsize_r, wsize_nxt;
  logic [15:0]       timeout_r, timeout_nxt;

  // Shared unit, store and helpers.
  alu_op_t           alu_op;
  logic [31:0]       alu_a;
  logic [31:0]       alu_b;
  alu_res_t          alu_res;
  logic              mem_we;
  logic [10:0]       mem_rdata;
  logic [10:0]       len_clamped;
  logic [15:0]       tick_inc;
  logic [15:0]       tick_limit;
  logic [6:0]        eff_win;
  logic [SLOT_W:0]   slot_sum;
  logic [SLOT_W-1:0] slot_adv;
  logic              out_free;
  logic              in_take;

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    logic [SLOT_W-1:0] r;
    if (s == SLOT_W'(WINDOW_MAX - 1)) begin
      r = '0;
    end else begin
      r = s + 1'b1;
    end
    return r;
  endfunction

  gbn_alu u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res)
  );

  gbn_slot_mem #(
    .DEPTH (WINDOW_MAX),
    .AW    (SLOT_W)
  ) u_slot_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (next_slot_r),
    .wr_data (len_clamped),
    .rd_addr (cur_slot_r),
    .rd_data (mem_rdata)
  );

  // Derived values used by several steps.
  always_comb begin
    tick_inc   = tick_r + 16'd1;
    tick_limit = (timeout_r == 16'd0) ? 16'd1 : timeout_r;
    eff_win    = (wsize_r == 7'd0) ? 7'd1 : wsize_r;
    if (eff_win > 7'(EFF_CAP)) begin
      eff_win = 7'(EFF_CAP);
    end
    if (17'(clen_r) > 17'(MAX_PAYLOAD)) begin
      len_clamped = 11'(MAX_PAYLOAD);
    end else begin
      len_clamped = clen_r;
    end
    slot_sum = {1'b0, base_slot_r} + diff_r[SLOT_W:0];
    if (slot_sum >= (SLOT_W + 1)'(WINDOW_MAX)) begin
      slot_sum = slot_sum - (SLOT_W + 1)'(WINDOW_MAX);
    end
    slot_adv = slot_sum[SLOT_W-1:0];
  end

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // Operand selection for the shared unit in each step.
  always_comb begin
    alu_op = ALU_SUB;
    alu_a  = '0;
    alu_b  = '0;
    unique case (state_r)
      S_DEC: begin
        case (op_r)
          OP_ACK: begin
            alu_a = aseq_r;
            alu_b = (phase_r == PH_START) ? 32'd0 : base_r;
          end
          OP_TICK: begin
            if (phase_r == PH_START) begin
              alu_a = {16'd0, tick_inc};
              alu_b = {16'd0, tick_limit};
            end else begin
              alu_a = base_r;
              alu_b = next_seq_r;
            end
          end
          OP_CHUNK: begin
            alu_a = next_seq_r;
            alu_b = base_r;
          end
          default: ;
        endcase
      end
      S_ACK2: begin
        alu_a = next_seq_r;
        alu_b = aseq_r;
      end
      S_TICK: begin
        alu_a = {16'd0, tick_inc};
        alu_b = {16'd0, tick_limit};
      end
      S_CHUNK2: begin
        alu_a = diff_r;
        alu_b = {25'd0, eff_win};
      end
      S_CHUNK3: begin
        alu_op = ALU_INC;
        alu_a  = next_seq_r;
      end
      S_RS_RD: begin
        alu_op = ALU_INC;
        alu_a  = cur_seq_r;
      end
      S_RS_CMP: begin
        alu_a = seq_inc_r;
        alu_b = next_seq_r;
      end
      default: ;
    endcase
  end

  // Sequencer: decides each step, the next window state and the pending result.
  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    base_nxt      = base_r;
    next_seq_nxt  = next_seq_r;
    done_nxt      = done_r;
    tick_nxt      = tick_r;
    base_slot_nxt = base_slot_r;
    next_slot_nxt = next_slot_r;
    cur_seq_nxt   = cur_seq_r;
    cur_slot_nxt  = cur_slot_r;
    seq_inc_nxt   = seq_inc_r;
    diff_nxt      = diff_r;
    eq_nxt        = eq_r;
    pend_nxt      = pend_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    op_nxt        = op_r;
    atype_nxt     = atype_r;
    aseq_nxt      = aseq_r;
    clen_nxt      = clen_r;
    wsize_nxt     = wsize_r;
    timeout_nxt   = timeout_r;
    mem_we        = 1'b0;

    // Configuration writes.
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_WINDOW_SIZE: wsize_nxt = cfg_data[6:0];
        CFG_TIMEOUT:     timeout_nxt = cfg_data;
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_take) begin
          op_nxt    = in_opcode;
          atype_nxt = in_ack_type;
          aseq_nxt  = in_ack_seq;
          clen_nxt  = in_chunk_length;
          state_nxt = S_DEC;
        end
      end

      S_DEC: begin
        state_nxt = S_IDLE;
        case (op_r)
          OP_BEGIN: begin
            phase_nxt     = PH_START;
            base_nxt      = '0;
            next_seq_nxt  = '0;
            done_nxt      = 1'b0;
            tick_nxt      = '0;
            base_slot_nxt = '0;
            next_slot_nxt = '0;
            pend_nxt      = '{PKT_START, 32'd0, 11'd0, 6'd0, 1'b0, 1'b0, 1'b1};
            state_nxt     = S_EMIT;
          end
          OP_TICK: begin
            if (phase_r == PH_START) begin
              if (!alu_res.borrow) begin
                tick_nxt  = '0;
                pend_nxt  = '{PKT_START, 32'd0, 11'd0, 6'd0, 1'b1, 1'b0, 1'b1};
                state_nxt = S_EMIT;
              end else begin
                tick_nxt = tick_inc;
              end
            end else if (phase_r == PH_DATA && !alu_res.zero) begin
              state_nxt = S_TICK;
            end
          end
          OP_ACK: begin
            if (atype_r == ACK_TYPE_ACK) begin
              if (phase_r == PH_START) begin
                if (alu_res.zero) begin
                  phase_nxt = PH_DATA;
                  tick_nxt  = '0;
                end
              end else if (phase_r == PH_DATA && !alu_res.borrow) begin
                diff_nxt  = alu_res.sum;
                state_nxt = S_ACK2;
              end
            end
          end
          default: begin
            // Offered chunk.
            if (phase_r != PH_DATA || done_r) begin
              pend_nxt  = '{PKT_DATA, 32'd0, 11'd0, 6'd0, 1'b0, 1'b1, 1'b1};
              state_nxt = S_EMIT;
            end else if (clen_r == 11'd0) begin
              done_nxt = 1'b1;
              if (alu_res.zero) begin
                phase_nxt = PH_DONE;
                pend_nxt  = '{PKT_END, 32'd0, 11'd0, 6'd0, 1'b0, 1'b0, 1'b1};
                state_nxt = S_EMIT;
              end
            end else begin
              diff_nxt  = alu_res.sum;
              eq_nxt    = alu_res.zero;
              state_nxt = S_CHUNK2;
            end
          end
        endcase
      end

      // Upper bound of a data-phase ACK, then move the base.
      S_ACK2: begin
        state_nxt = S_IDLE;
        if (!alu_res.borrow) begin
          base_nxt      = aseq_r;
          base_slot_nxt = slot_adv;
          tick_nxt      = '0;
          if (done_r && alu_res.zero) begin
            phase_nxt = PH_DONE;
            pend_nxt  = '{PKT_END, 32'd0, 11'd0, 6'd0, 1'b0, 1'b0, 1'b1};
            state_nxt = S_EMIT;
          end
        end
      end

      // Window room and saturation check for a chunk.
      S_CHUNK2: begin
        if (alu_res.borrow && !(&next_seq_r)) begin
          state_nxt = S_CHUNK3;
        end else begin
          pend_nxt  = '{PKT_DATA, 32'd0, 11'd0, 6'd0, 1'b0, 1'b1, 1'b1};
          state_nxt = S_EMIT;
        end
      end

      // Number the chunk, store its length and advance next_seq.
      S_CHUNK3: begin
        mem_we        = 1'b1;
        pend_nxt      = '{PKT_DATA, next_seq_r, len_clamped, 6'(next_slot_r),
                          1'b0, 1'b0, 1'b1};
        if (eq_r) begin
          tick_nxt = '0;
        end
        next_seq_nxt  = alu_res.sum;
        next_slot_nxt = slot_inc(next_slot_r);
        state_nxt     = S_EMIT;
      end

      // Data-phase timer with data outstanding.
      S_TICK: begin
        if (!alu_res.borrow) begin
          tick_nxt     = '0;
          cur_seq_nxt  = base_r;
          cur_slot_nxt = base_slot_r;
          state_nxt    = S_RS_RD;
        end else begin
          tick_nxt  = tick_inc;
          state_nxt = S_IDLE;
        end
      end

      // Resend loop: read the slot length and step the sequence number.
      S_RS_RD: begin
        seq_inc_nxt = alu_res.sum;
        state_nxt   = S_RS_CMP;
      end

      S_RS_CMP: begin
        pend_nxt     = '{PKT_DATA, cur_seq_r, mem_rdata, 6'(cur_slot_r),
                         1'b1, 1'b0, alu_res.zero};
        cur_seq_nxt  = seq_inc_r;
        cur_slot_nxt = slot_inc(cur_slot_r);
        state_nxt    = S_EMIT;
      end

      // Hand the pending result to the output register when it is free.
      S_EMIT: begin
        if (out_free) begin
          out_nxt       = pend_r;
          out_valid_nxt = 1'b1;
          state_nxt     = pend_r.last ? S_IDLE : S_RS_RD;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // State, window registers and the output register.
  always_ff @(posedge clk) begin
    cur_seq_r <= cur_seq_nxt;
    seq_inc_r <= seq_inc_nxt;
    diff_r    <= diff_nxt;
    eq_r      <= eq_nxt;
    pend_r    <= pend_nxt;
    out_r     <= out_nxt;
    op_r      <= op_nxt;
    atype_r   <= atype_nxt;
    aseq_r    <= aseq_nxt;
    clen_r    <= clen_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_IDLE;
      base_r      <= '0;
      next_seq_r  <= '0;
      done_r      <= 1'b0;
      tick_r      <= '0;
      base_slot_r <= '0;
      next_slot_r <= '0;
      cur_slot_r  <= '0;
      out_valid_r <= 1'b0;
      wsize_r     <= 7'd4;
      timeout_r   <= 16'd500;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      base_r      <= base_nxt;
      next_seq_r  <= next_seq_nxt;
      done_r      <= done_nxt;
      tick_r      <= tick_nxt;
      base_slot_r <= base_slot_nxt;
      next_slot_r <= next_slot_nxt;
      cur_slot_r  <= cur_slot_nxt;
      out_valid_r <= out_valid_nxt;
      wsize_r     <= wsize_nxt;
      timeout_r   <= timeout_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_pkt_type       = out_r.pkt_type;
  assign out_seq_number     = out_r.seq_number;
  assign out_payload_length = out_r.payload_length;
  assign out_slot_index     = out_r.slot_index;
  assign out_is_resend      = out_r.is_resend;
  assign out_status         = out_r.status;
  assign out_last           = out_r.last;

  // Window never holds more outstanding packets than the largest allowed window.
  `GBN_ASSERT_NOW(a_window_bound, 1'b1, (next_seq_r - base_r) <= 32'(EFF_CAP), "window overrun")

  // Before any session the sequence counters stay at zero.
  `GBN_ASSERT_NOW(a_idle_counters, phase_r == PH_IDLE, base_r == '0 && next_seq_r == '0, "counters moved outside a session")

  // A sent data packet never carries more than the payload limit.
  `GBN_ASSERT_NOW(a_len_limit, out_valid_r && out_r.pkt_type == PKT_DATA && !out_r.status, 17'(out_r.payload_length) <= 17'(MAX_PAYLOAD), "payload length above limit")

  // A taken item keeps the block busy in the following cycle.
  `GBN_ASSERT_NEXT(a_busy_after_take, in_take, in_stall, "block ready right after a transfer")

endmodule

@@ tb/sv/go_back_n_window_sender_tb.sv @@
// Self-checking testbench of the go-back-n window sender: directed cases, then random traffic.
module go_back_n_window_sender_tb;
  import gbn_pkg::*;

  localparam int RESET_CYCLES  = 3;
  localparam int MAX_BURST     = 64;
  localparam int SETTLE_CYCLES = 16;
  localparam int DRAIN_CYCLES  = 250;
  localparam int CYCLE_LIMIT   = 3000000;

  typedef enum logic [1:0] {
    SESS_IDLE,
    SESS_WAIT_START_ACK,
    SESS_DATA,
    SESS_DONE
  } sess_phase_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [1:0]            in_opcode;
  logic [1:0]            in_ack_type;
  logic [31:0]           in_ack_seq;
  logic [10:0]           in_chunk_length;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [1:0]            out_pkt_type;
  logic [31:0]           out_seq_number;
  logic [10:0]           out_payload_length;
  logic [5:0]            out_slot_index;
  logic                  out_is_resend;
  logic                  out_status;
  logic                  out_last;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Shadow of the sender: registers, session state and the slot length store.
  logic [6:0]    reg_window;
  logic [15:0]   reg_timeout;
  sess_phase_t   sess_phase;
  logic [31:0]   sess_base;
  logic [31:0]   sess_next;
  logic          sess_exhausted;
  logic [15:0]   sess_ticks;
  logic [10:0]   slot_bytes [WINDOW_MAX_DEF];

  // Packets still owed by the block, oldest first.
  result_t pending_packets [$];

  int mismatches  = 0;
  int cycle_count = 0;
  int burst_left  = 0;
  int stall_mode  = 0;
  int stall_span  = 0;

  go_back_n_window_sender uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_opcode          (in_opcode),
    .in_ack_type        (in_ack_type),
    .in_ack_seq         (in_ack_seq),
    .in_chunk_length    (in_chunk_length),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_pkt_type       (out_pkt_type),
    .out_seq_number     (out_seq_number),
    .out_payload_length (out_payload_length),
    .out_slot_index     (out_slot_index),
    .out_is_resend      (out_is_resend),
    .out_status         (out_status),
    .out_last           (out_last),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Cycle counter and run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // The receiver switches between randomly chosen stall patterns, each held for a random span.
  always @(posedge clk) begin
    if (stall_span == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_span <= $urandom_range(8, 80);
    end else begin
      stall_span <= stall_span - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= ((cycle_count % 7) < 3);
    endcase
  end

  task automatic flag_mismatch(input string msg);
    mismatches++;
    $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
  endtask

  task automatic check_field(input string field, input logic [31:0] got,
                             input logic [31:0] want, input logic [31:0] seq);
    if (got !== want)
      flag_mismatch($sformatf("%s got %0d, expected %0d (expected seq %0d)",
                              field, got, want, seq));
  endtask

  // Every result transfer is compared with the oldest packet still owed.
  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_packets.size() == 0) begin
        flag_mismatch($sformatf("unexpected packet type %0d seq %0d",
                                out_pkt_type, out_seq_number));
      end else begin
        want = pending_packets.pop_front();
        check_field("pkt_type", out_pkt_type, want.pkt_type, want.seq_number);
        check_field("seq_number", out_seq_number, want.seq_number, want.seq_number);
        check_field("payload_length", out_payload_length, want.payload_length,
                    want.seq_number);
        check_field("slot_index", out_slot_index, want.slot_index, want.seq_number);
        check_field("is_resend", out_is_resend, want.is_resend, want.seq_number);
        check_field("status", out_status, want.status, want.seq_number);
        check_field("last", out_last, want.last, want.seq_number);
      end
    end
  end

  function automatic result_t make_pkt(input logic [1:0] kind, input logic [31:0] seq,
                                       input logic [10:0] len, input logic [5:0] slot,
                                       input logic resend, input logic refused,
                                       input logic fin);
    result_t r;
    r.pkt_type       = kind;
    r.seq_number     = seq;
    r.payload_length = len;
    r.slot_index     = slot;
    r.is_resend      = resend;
    r.status         = refused;
    r.last           = fin;
    return r;
  endfunction

  // Number of data packets that may be outstanding under the current setting.
  function automatic logic [31:0] window_limit();
    logic [31:0] w;
    w = {25'd0, reg_window};
    if (w == 0) w = 1;
    if (w > WINDOW_MAX_DEF) w = WINDOW_MAX_DEF;
    if (w > MAX_BURST) w = MAX_BURST;
    return w;
  endfunction

  // Advances the retransmit timer by one tick; true when it runs out.
  function automatic logic timer_expired();
    logic [15:0] limit;
    limit = (reg_timeout == 0) ? 16'd1 : reg_timeout;
    sess_ticks = sess_ticks + 16'd1;
    if (sess_ticks >= limit) begin
      sess_ticks = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Updates the shadow state for one input transfer and queues the packets it owes.
  task automatic predict_packets(input logic [1:0] op, input logic [1:0] atype,
                                 input logic [31:0] aseq, input logic [10:0] clen);
    logic [31:0] s;
    logic [10:0] len;
    logic [5:0]  slot;
    logic        open;
    case (op)
      OP_BEGIN: begin
        sess_phase     = SESS_WAIT_START_ACK;
        sess_base      = '0;
        sess_next      = '0;
        sess_exhausted = 1'b0;
        sess_ticks     = '0;
        pending_packets.push_back(make_pkt(PKT_START, '0, '0, '0, 1'b0, 1'b0, 1'b1));
      end
      OP_TICK: begin
        if (sess_phase == SESS_WAIT_START_ACK) begin
          if (timer_expired())
            pending_packets.push_back(make_pkt(PKT_START, '0, '0, '0, 1'b1, 1'b0, 1'b1));
        end else if (sess_phase == SESS_DATA && sess_base != sess_next) begin
          // A timeout resends everything from the base up to the next sequence.
          if (timer_expired()) begin
            for (s = sess_base; s != sess_next; s++) begin
              slot = 6'(s % WINDOW_MAX_DEF);
              pending_packets.push_back(make_pkt(PKT_DATA, s, slot_bytes[slot], slot,
                                                 1'b1, 1'b0, (s + 1 == sess_next)));
            end
          end
        end
      end
      OP_ACK: begin
        if (atype == ACK_TYPE_ACK) begin
          if (sess_phase == SESS_WAIT_START_ACK) begin
            if (aseq == 0) begin
              sess_phase = SESS_DATA;
              sess_ticks = '0;
            end
          end else if (sess_phase == SESS_DATA && aseq >= sess_base && aseq <= sess_next) begin
            sess_base  = aseq;
            sess_ticks = '0;
            if (sess_exhausted && sess_base == sess_next) begin
              sess_phase = SESS_DONE;
              pending_packets.push_back(make_pkt(PKT_END, '0, '0, '0, 1'b0, 1'b0, 1'b1));
            end
          end
        end
      end
      default: begin
        open = (sess_phase == SESS_DATA) && !sess_exhausted;
        if (open && clen == 0) begin
          sess_exhausted = 1'b1;
          if (sess_base == sess_next) begin
            sess_phase = SESS_DONE;
            pending_packets.push_back(make_pkt(PKT_END, '0, '0, '0, 1'b0, 1'b0, 1'b1));
          end
        end else if (open && (sess_next - sess_base) < window_limit() &&
                     sess_next != 32'hFFFF_FFFF) begin
          len  = (clen > MAX_PAYLOAD) ? 11'(MAX_PAYLOAD) : clen;
          slot = 6'(sess_next % WINDOW_MAX_DEF);
          if (sess_base == sess_next) sess_ticks = '0;
          slot_bytes[slot] = len;
          pending_packets.push_back(make_pkt(PKT_DATA, sess_next, len, slot,
                                             1'b0, 1'b0, 1'b1));
          sess_next = sess_next + 1;
        end else begin
          pending_packets.push_back(make_pkt(PKT_DATA, '0, '0, '0, 1'b0, 1'b1, 1'b1));
        end
      end
    endcase
  endtask

  // Offers one item and waits for its transfer; bursts end with a random gap.
  task automatic send_item(input logic [1:0] op, input logic [1:0] atype,
                           input logic [31:0] aseq, input logic [10:0] clen);
    int gap;
    in_valid        <= 1'b1;
    in_opcode       <= op;
    in_ack_type     <= atype;
    in_ack_seq      <= aseq;
    in_chunk_length <= clen;
    do @(posedge clk); while (in_stall);
    predict_packets(op, atype, aseq, clen);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 20) : $urandom_range(1, 3);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
    end
  endtask

  // Holds the input side until the block has delivered every packet owed.
  task automatic wait_for_all_packets();
    in_valid   <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending_packets.size() != 0);
  endtask

  // Register writes happen only once the block has gone quiet.
  task automatic settle_and_write(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
    wait_for_all_packets();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_WINDOW_SIZE) reg_window = data[6:0];
    else if (idx == CFG_TIMEOUT) reg_timeout = data;
  endtask

  function automatic logic [10:0] random_chunk_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 2) return 11'd0;
    if (r < 10) return 11'($urandom_range(MAX_PAYLOAD + 1, 2047));
    if (r < 14) return 11'(MAX_PAYLOAD);
    if (r < 17) return 11'd1;
    return 11'($urandom_range(1, MAX_PAYLOAD));
  endfunction

  // ACK numbers in the data phase: mostly inside the window, some outside it.
  function automatic logic [31:0] random_ack_seq();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return sess_next;
    if (r < 75) return sess_base + $urandom_range(0, sess_next - sess_base);
    if (r < 85 && sess_base != 0) return $urandom_range(0, sess_base - 1);
    return $urandom();
  endfunction

  // Random traffic that follows the session protocol most of the time.
  task automatic drive_traffic(input int items, input int chunk_pct, input int ack_pct);
    int count;
    int pick;
    logic paused;
    count  = 0;
    paused = 1'b0;
    while (count < items) begin
      if (!paused && count >= items / 2) begin
        wait_for_all_packets();
        paused = 1'b1;
      end
      pick = $urandom_range(0, 99);
      case (sess_phase)
        SESS_IDLE, SESS_DONE: begin
          if (pick < 85) begin
            send_item(OP_BEGIN, 2'($urandom()), $urandom(), 11'($urandom()));
            count++;
          end else if (pick < 92) begin
            send_item(OP_CHUNK, 2'($urandom()), $urandom(), random_chunk_len());
            count++;
          end else begin
            // Ticks and ACKs here are ignored and do not count.
            send_item((pick < 96) ? OP_TICK : OP_ACK, 2'($urandom()), $urandom(),
                      11'($urandom()));
          end
        end
        SESS_WAIT_START_ACK: begin
          if (pick < 65)
            send_item(OP_ACK, ACK_TYPE_ACK, ($urandom_range(0, 9) == 0) ? $urandom() : 32'd0,
                      11'($urandom()));
          else if (pick < 75)
            send_item(OP_ACK, 2'($urandom()), $urandom(), 11'($urandom()));
          else
            send_item(OP_TICK, 2'($urandom()), $urandom(), 11'($urandom()));
          count++;
        end
        default: begin
          if (pick < 2)
            send_item(OP_BEGIN, 2'($urandom()), $urandom(), 11'($urandom()));
          else if (pick < 2 + chunk_pct)
            send_item(OP_CHUNK, 2'($urandom()), $urandom(), random_chunk_len());
          else if (pick < 2 + chunk_pct + ack_pct)
            send_item(OP_ACK, ($urandom_range(0, 9) == 0) ? 2'($urandom_range(0, 2)) :
                      ACK_TYPE_ACK, random_ack_seq(), 11'($urandom()));
          else
            send_item(OP_TICK, 2'($urandom()), $urandom(), 11'($urandom()));
          count++;
        end
      endcase
      if ($urandom_range(0, 99) == 0) wait_for_all_packets();
    end
  endtask

  // Before any session, ticks and ACKs are ignored and chunks are refused.
  task automatic test_idle_items();
    send_item(OP_TICK, 2'd0, 32'd0, 11'd0);
    send_item(OP_ACK, ACK_TYPE_ACK, 32'd0, 11'd0);
    send_item(OP_CHUNK, 2'd0, 32'd0, 11'd100);
  endtask

  // START goes out, is resent on timeout, and only an ACK of sequence zero ends the wait.
  task automatic test_start_handshake();
    settle_and_write(CFG_TIMEOUT, 16'd2);
    send_item(OP_BEGIN, 2'd0, 32'd0, 11'd0);
    send_item(OP_TICK, 2'd0, 32'd0, 11'd0);
    send_item(OP_TICK, 2'd0, 32'd0, 11'd0);
    send_item(OP_ACK, PKT_END, 32'd0, 11'd0);
    send_item(OP_ACK, ACK_TYPE_ACK, 32'd5, 11'd0);
    send_item(OP_ACK, ACK_TYPE_ACK, 32'd0, 11'd0);
  endtask

  // With the reset window of four, the fifth chunk is refused; oversized chunks saturate.
  task automatic test_window_limit();
    send_item(OP_CHUNK, 2'd0, 32'd0, 11'h7FF);
    send_item(OP_CHUNK, 2'd0, 32'd0, 11'(MAX_PAYLOAD));
    send_item(OP_CHUNK, 2'd0, 32'd0, 11'd1);
    send_item(OP_CHUNK, 2'd0, 32'd0, 11'd5);
    send_item(OP_CHUNK, 2'd0, 32'd0, 11'd7);
  endtask

  // ACKs outside the window are ignored; a timeout resends what is outstanding.
  task automatic test_ack_window();
    send_item(OP_ACK, ACK_TYPE_ACK, 32'd9, 11'd0);
    send_item(OP_ACK, ACK_TYPE_ACK, 32'd2, 11'd0);
    send_item(OP_ACK, ACK_TYPE_ACK, 32'd1, 11'd0);
    send_item(OP_TICK, 2'd0, 32'd0, 11'd0);
    send_item(OP_TICK, 2'd0, 32'd0, 11'd0);
  endtask

  // Exhausted input waits for the last ACK before END; later items are ignored or refused.
  task automatic test_end_of_input();
    send_item(OP_CHUNK, 2'd0, 32'd0, 11'd0);
    send_item(OP_CHUNK, 2'd0, 32'd0, 11'd3);
    send_item(OP_ACK, ACK_TYPE_ACK, 32'd4, 11'd0);
    send_item(OP_TICK, 2'd0, 32'd0, 11'd0);
  endtask

  // A full window of 64 packets, one refusal, then a timeout that resends all of them.
  task automatic test_full_window_resend();
    settle_and_write(CFG_WINDOW_SIZE, 16'd64);
    settle_and_write(CFG_TIMEOUT, 16'd4);
    send_item(OP_BEGIN, 2'($urandom()), $urandom(), 11'($urandom()));
    send_item(OP_ACK, ACK_TYPE_ACK, 32'd0, 11'($urandom()));
    repeat (MAX_BURST + 1)
      send_item(OP_CHUNK, 2'($urandom()), $urandom(), 11'($urandom_range(1, 2047)));
    repeat (4) send_item(OP_TICK, 2'($urandom()), $urandom(), 11'($urandom()));
    send_item(OP_ACK, ACK_TYPE_ACK, sess_next, 11'($urandom()));
    send_item(OP_CHUNK, 2'($urandom()), $urandom(), 11'd0);
  endtask

  // Random traffic under a series of register settings, the extremes among them.
  task automatic test_random_traffic();
    settle_and_write(CFG_WINDOW_SIZE, 16'h0000);
    settle_and_write(CFG_TIMEOUT, 16'h0000);
    drive_traffic(50, 45, 30);
    settle_and_write(CFG_WINDOW_SIZE, 16'hFF80);
    settle_and_write(CFG_TIMEOUT, 16'd2);
    drive_traffic(40, 45, 30);
    settle_and_write(CFG_WINDOW_SIZE, 16'h007F);
    settle_and_write(CFG_TIMEOUT, 16'd6);
    drive_traffic(80, 65, 10);
    settle_and_write(CFG_WINDOW_SIZE, 16'd64);
    settle_and_write(CFG_TIMEOUT, 16'hFFFF);
    drive_traffic(60, 50, 30);
    settle_and_write(CFG_WINDOW_SIZE, 16'd1);
    settle_and_write(CFG_TIMEOUT, 16'd3);
    drive_traffic(50, 45, 30);
    repeat (3) begin
      settle_and_write(CFG_WINDOW_SIZE, {9'($urandom()), 7'($urandom_range(1, 64))});
      settle_and_write(CFG_TIMEOUT, 16'($urandom_range(1, 12)));
      drive_traffic(35, 50, 25);
    end
  endtask

  initial begin
    in_valid        <= 1'b0;
    in_opcode       <= OP_TICK;
    in_ack_type     <= '0;
    in_ack_seq      <= '0;
    in_chunk_length <= '0;
    cfg_valid       <= 1'b0;
    cfg_index       <= CFG_WINDOW_SIZE;
    cfg_data        <= '0;
    rst_n           <= 1'b0;
    reg_window      = 7'd4;
    reg_timeout     = 16'd500;
    sess_phase      = SESS_IDLE;
    sess_base       = '0;
    sess_next       = '0;
    sess_exhausted  = 1'b0;
    sess_ticks      = '0;
    foreach (slot_bytes[i]) slot_bytes[i] = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    test_idle_items();
    test_start_handshake();
    test_window_limit();
    test_ack_window();
    test_end_of_input();
    test_full_window_resend();
    test_random_traffic();

    // Let the last results drain, then give the block time to show stray ones.
    wait_for_all_packets();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_packets.size() != 0)
      flag_mismatch($sformatf("%0d packets never delivered", pending_packets.size()));
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
